// ===== rtl/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
`default_nettype none

package deq_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WORD  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned IN_VALUE_W = 32;

  // Per-cycle control that one chain hands to all of its cells
  typedef struct packed {
    logic shift_up;    // take the word of the lower-index neighbor
    logic shift_down;  // take the word of the higher-index neighbor
    logic wr_en;       // write the pushed word into the addressed cell
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/deq_cell.sv =====
// One storage cell of a word chain: hold, shift from a neighbor, or take a write.
`default_nettype none

module deq_cell #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned IDX        = 0
) (
  input  wire                      clk,
  input  deq_pkg::cell_ctrl_t      ctl,
  input  wire  [IDX_W-1:0]         wr_idx,
  input  wire  [WORD_WIDTH-1:0]    wr_word,
  input  wire  [WORD_WIDTH-1:0]    lower_word,
  input  wire  [WORD_WIDTH-1:0]    upper_word,
  output logic [WORD_WIDTH-1:0]    word
);
  import deq_pkg::*;

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;
  logic                  hit;

  // Decode the write address against this cell's place in the chain
  assign hit = ctl.wr_en && (wr_idx == IDX_W'(IDX));

  // Select the next word; a direct write wins over a shift
  always_comb begin
    word_nxt = word_r;
    priority if (hit) begin
      word_nxt = wr_word;
    end else if (ctl.shift_up) begin
      word_nxt = lower_word;
    end else if (ctl.shift_down) begin
      word_nxt = upper_word;
    end else begin
      word_nxt = word_r;
    end
  end

  // Hold the word
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_core.sv =====
// Top level of the double-ended queue: two cell chains, the entry count and the result register.
`default_nettype none

// Double-ended queue of WORD_WIDTH-bit words, up to DEPTH entries. A command is
// transferred at every rising edge with start high; busy never rises, so one
// command can follow another in every cycle. Each command gives exactly one result,
// marked by out_valid in the cycle after the command's transfer and shown for that
// single cycle; the receiver must take it then. The words live in two chains of
// cells updated in parallel: one kept packed toward its first cell, so the front
// word always sits in cell 0, and one kept packed toward its last cell, so the back
// word always sits there. Every push, pop or peek therefore touches only
// neighbor-to-neighbor moves or one addressed write, which is what sets the one
// command per cycle figure. Push into a full queue returns status 3, pop or peek
// on an empty queue status 2; neither changes the contents. Data is zero unless
// status reports a returned word. Code 7 is ignored with status 0.

module double_ended_queue_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [2:0]                        in_cmd,
  input  wire  [deq_pkg::IN_VALUE_W-1:0]    in_value,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [deq_pkg::OUT_DATA_W-1:0]    out_data
);
  import deq_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                  accept;
  cmd_t                  cmd;
  logic [WORD_WIDTH-1:0] push_word;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [OUT_DATA_W-1:0] rd_data;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  full;
  logic                  empty;

  cell_ctrl_t            lo_ctl;
  cell_ctrl_t            hi_ctl;
  logic [IDX_W-1:0]      lo_wr_idx;
  logic [IDX_W-1:0]      hi_wr_idx;
  logic [WORD_WIDTH-1:0] lo_word [DEPTH];
  logic [WORD_WIDTH-1:0] hi_word [DEPTH];

  status_t               status_nxt;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Commands are taken in every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(in_cmd);

  // Fit the pushed value to the word width
  generate
    if (WORD_WIDTH > IN_VALUE_W) begin : g_win_wide
      assign push_word = {{(WORD_WIDTH - IN_VALUE_W){1'b0}}, in_value};
    end else begin : g_win_narrow
      assign push_word = in_value[WORD_WIDTH-1:0];
    end
  endgenerate

  // Fit the returned word to the data port
  generate
    if (WORD_WIDTH < OUT_DATA_W) begin : g_wout_narrow
      assign rd_data = {{(OUT_DATA_W - WORD_WIDTH){1'b0}}, rd_word};
    end else begin : g_wout_wide
      assign rd_data = rd_word[OUT_DATA_W-1:0];
    end
  endgenerate

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Write addresses: after the last word in the low chain, before the first in the high chain
  assign lo_wr_idx = count_r[IDX_W-1:0];
  assign hi_wr_idx = IDX_W'(DEPTH - 1) - count_r[IDX_W-1:0];

  // Decode the command into chain moves, count update and result
  always_comb begin
    lo_ctl     = '0;
    hi_ctl     = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_word    = '0;
    if (accept) begin
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            lo_ctl.shift_up = 1'b1;
            hi_ctl.wr_en    = 1'b1;
            count_nxt       = count_r + CNT_W'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            lo_ctl.wr_en      = 1'b1;
            hi_ctl.shift_down = 1'b1;
            count_nxt         = count_r + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt        = ST_WORD;
            rd_word           = lo_word[0];
            lo_ctl.shift_down = 1'b1;
            count_nxt         = count_r - CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt      = ST_WORD;
            rd_word         = hi_word[DEPTH-1];
            hi_ctl.shift_up = 1'b1;
            count_nxt       = count_r - CNT_W'(1);
          end
        end
        CMD_PEEK_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt = ST_WORD;
            rd_word    = lo_word[0];
          end
        end
        CMD_PEEK_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt = ST_WORD;
            rd_word    = hi_word[DEPTH-1];
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Build both chains; the pushed word enters at the open ends
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] lo_lower;
      logic [WORD_WIDTH-1:0] lo_upper;
      logic [WORD_WIDTH-1:0] hi_lower;
      logic [WORD_WIDTH-1:0] hi_upper;

      if (i == 0) begin : g_first
        assign lo_lower = push_word;
        assign hi_lower = push_word;
      end else begin : g_inner_lo
        assign lo_lower = lo_word[i-1];
        assign hi_lower = hi_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign lo_upper = push_word;
        assign hi_upper = push_word;
      end else begin : g_inner_hi
        assign lo_upper = lo_word[i+1];
        assign hi_upper = hi_word[i+1];
      end

      deq_cell #(
        .WORD_WIDTH (WORD_WIDTH),
        .IDX_W      (IDX_W),
        .IDX        (i)
      ) u_lo_cell (
        .clk        (clk),
        .ctl        (lo_ctl),
        .wr_idx     (lo_wr_idx),
        .wr_word    (push_word),
        .lower_word (lo_lower),
        .upper_word (lo_upper),
        .word       (lo_word[i])
      );

      deq_cell #(
        .WORD_WIDTH (WORD_WIDTH),
        .IDX_W      (IDX_W),
        .IDX        (i)
      ) u_hi_cell (
        .clk        (clk),
        .ctl        (hi_ctl),
        .wr_idx     (hi_wr_idx),
        .wr_word    (push_word),
        .lower_word (hi_lower),
        .upper_word (hi_upper),
        .word       (hi_word[i])
      );
    end
  endgenerate

  // Advance the entry count and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Hold the result payload for its transfer
  always_ff @(posedge clk) begin
    out_status_r <= status_nxt;
    out_data_r   <= rd_data;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;

`ifndef SYNTHESIS
  // Count never runs past the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // Every transferred command gives a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("command without result");

  // A rejected push leaves the count alone
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK))
      |=> (count_r == $past(count_r)) && (out_status_r == ST_FULL))
    else $error("push into full queue changed state");

  // Data is zero unless a word is returned
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_WORD) |-> (out_data_r == '0))
    else $error("data not zero without returned word");

  // An empty-queue error is only reported when nothing was held
  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |-> ($past(count_r) == '0))
    else $error("empty error with words held");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/deq_checker.sv =====
// Result checker for the double-ended queue: watches both channels and checks each result.
module deq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire         busy,
  input  wire  [2:0]  in_cmd,
  input  wire  [31:0] in_value,
  input  wire         out_valid,
  input  wire  [1:0]  out_status,
  input  wire  [31:0] out_data,
  output int          errors,
  output int          pending
);
  import deq_pkg::*;

  typedef struct {
    status_t     status;
    logic [31:0] data;
  } deq_result_t;

  deq_result_t  predicted_results[$];

  // Shadow copy of the queue contents
  logic [31:0]  ring_words [DEPTH];
  int unsigned  front_pos;
  int unsigned  word_count;

  initial errors = 0;

  task automatic report(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Apply one command to the shadow queue and return the result it should give
  function automatic deq_result_t deque_apply(input logic [2:0] cmd, input logic [31:0] value);
    deq_result_t res;
    int unsigned pos;
    res.status = ST_OK;
    res.data   = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (word_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            front_pos = (front_pos + DEPTH - 1) % DEPTH;
            ring_words[front_pos] = value;
          end else begin
            ring_words[(front_pos + word_count) % DEPTH] = value;
          end
          word_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (word_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT)
            pos = front_pos;
          else
            pos = (front_pos + word_count - 1) % DEPTH;
          res.data   = ring_words[pos];
          res.status = ST_WORD;
          // Remove the word only on a pop
          if (cmd == CMD_POP_FRONT) begin
            front_pos = (front_pos + 1) % DEPTH;
            word_count--;
          end else if (cmd == CMD_POP_BACK) begin
            word_count--;
          end
        end
      end
      CMD_CLEAR: begin
        front_pos  = 0;
        word_count = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    deq_result_t want;
    if (!rst_n) begin
      predicted_results.delete();
      front_pos  = 0;
      word_count = 0;
    end else begin
      // Compare a result transfer with the oldest prediction first
      if (out_valid) begin
        if (predicted_results.size() == 0) begin
          report($sformatf("result with nothing predicted: status %0d data %h",
                           out_status, out_data));
        end else begin
          want = predicted_results.pop_front();
          if (out_status !== want.status)
            report($sformatf("status got %0d, predicted %0d", out_status, want.status));
          if (out_data !== want.data)
            report($sformatf("data got %h, predicted %h", out_data, want.data));
        end
      end
      // Predict the result of a command transfer
      if (start && !busy)
        predicted_results.push_back(deque_apply(in_cmd, in_value));
    end
    pending = predicted_results.size();
  end

endmodule

// ===== tb/sv/tb_double_ended_queue_core.sv =====
// Testbench top for the double-ended queue: clock, reset, command stimulus and verdict.
module tb_double_ended_queue_core;
  import deq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          ITEM_TARGET = 950;
  localparam logic [2:0]  CMD_UNUSED  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic [2:0]  in_cmd;
  logic [31:0] in_value;
  wire         busy;
  wire         out_valid;
  wire  [1:0]  out_status;
  wire  [31:0] out_data;
  int          errors;
  int          pending;
  int          sent;
  bit          no_idle;

  double_ended_queue_core #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (32)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_data   (out_data)
  );

  deq_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_data   (out_data),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  // Hold start low for a random number of cycles; mostly short, a few long
  task automatic idle_gap();
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(11, 40);
    repeat (gap) begin
      @(negedge clk);
      start    <= 1'b0;
      in_cmd   <= 3'($urandom);
      in_value <= $urandom;
    end
  endtask

  // Present one command and wait for its transfer
  task automatic send(input logic [2:0] cmd, input logic [31:0] value);
    @(negedge clk);
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd != CMD_UNUSED) sent++;
    idle_gap();
  endtask

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin
    int          seg_len;
    int          mode;
    int          r;
    int          waited;
    logic [2:0]  cmd;
    start    <= 1'b0;
    in_cmd   <= CMD_CLEAR;
    in_value <= '0;
    rst_n    <= 1'b0;
    sent     = 0;
    no_idle  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty queue: every read command errors; unused code is ignored
    send(CMD_POP_FRONT, rand_word());
    send(CMD_POP_BACK, rand_word());
    send(CMD_PEEK_FRONT, rand_word());
    send(CMD_PEEK_BACK, rand_word());
    send(CMD_UNUSED, 32'hFFFF_FFFF);
    send(CMD_CLEAR, 32'hFFFF_FFFF);
    // Value extremes at both ends, then read them back from both ends
    send(CMD_PUSH_FRONT, 32'h0000_0000);
    send(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send(CMD_PUSH_FRONT, 32'hA5A5_5A5A);
    send(CMD_PEEK_FRONT, 32'h0);
    send(CMD_PEEK_BACK, 32'h0);
    send(CMD_UNUSED, 32'h0);
    send(CMD_POP_BACK, 32'h0);
    send(CMD_POP_FRONT, 32'h0);
    send(CMD_POP_FRONT, 32'h0);
    send(CMD_POP_FRONT, 32'h0);
    // Clear a non-empty queue, then confirm it reads as empty
    send(CMD_PUSH_BACK, 32'h5A5A_A5A5);
    send(CMD_PUSH_BACK, 32'h8000_0001);
    send(CMD_CLEAR, 32'h0);
    send(CMD_PEEK_BACK, 32'h0);
    send(CMD_POP_BACK, 32'h0);

    // Random segments: fill bursts, drain bursts and mixed traffic
    while (sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      seg_len = $urandom_range(4, 24);
      mode    = $urandom_range(0, 9);
      repeat (seg_len) begin
        if (mode < 3) begin
          cmd = 3'($urandom_range(CMD_PUSH_FRONT, CMD_PUSH_BACK));
        end else if (mode < 6) begin
          cmd = 3'($urandom_range(CMD_POP_FRONT, CMD_PEEK_BACK));
        end else begin
          r = $urandom_range(0, 39);
          if (r == 0) cmd = CMD_CLEAR;
          else if (r == 1) cmd = CMD_UNUSED;
          else cmd = 3'($urandom_range(CMD_PUSH_FRONT, CMD_PEEK_BACK));
        end
        send(cmd, rand_word());
      end
    end
    no_idle = 1'b0;
    @(negedge clk);
    start <= 1'b0;

    // Drain outstanding results, then allow a few extra cycles
    waited = 0;
    while (pending != 0 && waited < 200) begin
      @(negedge clk);
      waited++;
    end
    repeat (5) @(negedge clk);

    if (pending != 0)
      $display("%0d predicted results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue_core.sv
tb/sv/deq_checker.sv
tb/sv/tb_double_ended_queue_core.sv
